>>> hdl/rgbds_pkg.sv
package rgbds_pkg;

  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int CH_SUM_W   = 9;
  localparam int NUM_CH     = 3;
  localparam int PSUM_W     = NUM_CH * CH_SUM_W;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(2);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [PSUM_W-1:0] psum_t;

  // Result in flight between the line buffer read and the output register
  typedef struct packed {
    psum_t bottom;
    logic  last_in_row;
    logic  last_in_frame;
  } stage_t;

  // Per-channel sum of two horizontal neighbours, 9 bits per channel
  function automatic psum_t pair_sum(pixel_t a, pixel_t b);
    psum_t r;
    r = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      r[ch*CH_SUM_W +: CH_SUM_W] = CH_SUM_W'(a[ch*CH_W +: CH_W]) +
                                   CH_SUM_W'(b[ch*CH_W +: CH_W]);
    end
    return r;
  endfunction

  // Sum of two pair sums, divided by four per channel
  function automatic pixel_t block_average(psum_t top, psum_t bottom);
    pixel_t               r;
    logic [CH_SUM_W:0]    s;
    r = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s = {1'b0, top[ch*CH_SUM_W +: CH_SUM_W]} + {1'b0, bottom[ch*CH_SUM_W +: CH_SUM_W]};
      r[ch*CH_W +: CH_W] = s[CH_SUM_W:2];
    end
    return r;
  endfunction

endpackage

>>> hdl/rgbds_ram.sv
module rgbds_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/rgb_downscale_2x2_box.sv
// 2x2 box-filter downscaler for a raster-order stream of 24-bit BGR pixels
// (blue 7:0, green 15:8, red 23:16), row padding already removed.
// Input channel: pixel_i with in_valid_i / in_ready_o. One transaction per
// input pixel; an even row stores per-column pair sums in a line buffer, the
// odd row below reads them back and yields one averaged pixel per 2x2 block.
// Output channel: out_pixel_o, last_in_row_o, last_in_frame_o with
// out_valid_o / out_ready_i. An odd last column or last row gives no output.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 = image width,
// 1 = image height) and cfg_data_i; always ready. Write only while idle.
// Throughput: one input pixel per clock while in_ready_o is high; the line
// buffer has separate read and write ports and sees at most one access per odd column.
// Pipeline: the input transaction that completes a block reads the line
// buffer into stage 1, and the result then moves on to the output register.
// Stall: the output register holds the result; one more result waits in the
// stage behind it, and in_ready_o falls only when both are full.
// Reset: counters and held pixel clear, width and height return to 2, all
// in-flight results are dropped; the line buffer is not cleared and needs
// no clearing pass, as every entry is written on an even row before use.
module rgb_downscale_2x2_box
  import rgbds_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_i,
  // averaged output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      out_pixel_o,
  output logic                  last_in_row_o,
  output logic                  last_in_frame_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  // compare widths: hold both the register value and the maximum
  localparam int WEW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
  localparam int HEW = (RW + 1 > HEIGHT_W) ? RW + 1 : HEIGHT_W;

  // configuration
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  // counters and held pixel
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  pixel_t        held_q;

  // pipeline
  logic   s1_valid_q, s1_valid_d;
  stage_t s1_q;
  logic   out_valid_q;
  pixel_t out_pixel_q;
  logic   out_lr_q, out_lf_q;

  logic   in_accept, s1_move;
  logic   pair_ok, odd_row, row_ok;
  logic   col_last, row_last, row_over;
  logic   lr, lf;
  logic   ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  psum_t  ps, ram_rdata;

  logic [WEW-1:0] w_eff, col_ext, out_w;
  logic [HEW-1:0] h_eff, row_ext, out_h;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero reads as one, clipped at the maximum
  always_comb begin
    priority if (width_q == '0) begin
      w_eff = WEW'(1);
    end else if (WEW'(width_q) > WEW'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(width_q);
    end
    priority if (height_q == '0) begin
      h_eff = HEW'(1);
    end else if (HEW'(height_q) > HEW'(MAX_HEIGHT)) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(height_q);
    end
  end

  // ---------------------------------------------------------------------
  // Position decode
  // ---------------------------------------------------------------------
  assign col_ext  = WEW'(col_q);
  assign row_ext  = HEW'(row_q);
  assign out_w    = w_eff >> 1;
  assign out_h    = h_eff >> 1;
  assign col_last = col_ext >= (w_eff - WEW'(1));
  assign row_last = row_ext >= (h_eff - HEW'(1));
  assign row_over = row_ext >= h_eff;

  // second pixel of a complete column pair
  assign pair_ok  = col_q[0] && (col_ext < {out_w[WEW-2:0], 1'b0});
  assign odd_row  = row_q[0];
  assign row_ok   = row_ext < {out_h[HEW-2:0], 1'b0};
  assign lr       = (col_ext >> 1) == (out_w - WEW'(1));
  assign lf       = lr && ((row_ext >> 1) == (out_h - HEW'(1)));

  assign ps       = pair_sum(held_q, pixel_i);
  assign ram_addr = AW'(col_q >> 1);

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  assign s1_move    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_accept  = in_valid_i && in_ready_o;

  // even rows write the pair sum, odd rows read the one stored above
  assign ram_we = in_accept && pair_ok && !odd_row;
  assign ram_re = in_accept && pair_ok && odd_row && row_ok;

  rgbds_ram #(
    .WIDTH (PSUM_W),
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ps),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Counters
  // ---------------------------------------------------------------------
  always_comb begin
    if (col_last) begin
      col_d = '0;
      row_d = row_last ? '0 : row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
      row_d = row_over ? '0 : row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
      if (!col_q[0]) begin
        held_q <= pixel_i;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: waits for line buffer data, then moves to the output register
  // ---------------------------------------------------------------------
  always_comb begin
    priority if (ram_re) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_move) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_q.bottom        <= ps;
      s1_q.last_in_row   <= lr;
      s1_q.last_in_frame <= lf;
    end
    if (s1_move && s1_valid_q) begin
      out_pixel_q <= block_average(ram_rdata, s1_q.bottom);
      out_lr_q    <= s1_q.last_in_row;
      out_lf_q    <= s1_q.last_in_frame;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_pixel_o     = out_pixel_q;
  assign last_in_row_o   = out_lr_q;
  assign last_in_frame_o = out_lf_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("line buffer read and write in one cycle");

  a_s1_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !$past(s1_valid_q) |-> $past(ram_re))
    else $error("stage 1 filled without a line buffer read");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q)
    else $error("stalled result lost in stage 1");

  a_no_read_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |-> !ram_re)
    else $error("line buffer read while stage 1 is blocked");

  a_frame_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_lf_q |-> out_lr_q)
    else $error("frame end without row end");

endmodule

>>> tb/rgb_downscale_2x2_box_tb.sv
module rgb_downscale_2x2_box_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbds_pkg::*;

  localparam int          MAX_W         = 2048;
  localparam int          MAX_H         = 4096;
  localparam int          LINE_SLOTS    = MAX_W / 2;
  // result passes stage 1, then the output register; a little margin
  localparam int          SETTLE_CYCLES = 4;
  localparam int          RANDOM_ITEMS  = 900;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int          MAX_REPORTS   = 100;
  // index with no register behind it; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

  // one averaged pixel as the output channel presents it
  typedef struct packed {
    pixel_t avg;
    logic   row_end;
    logic   frame_end;
  } shrunk_px_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      pixel_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      out_pixel_o;
  logic                  last_in_row_o;
  logic                  last_in_frame_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  rgb_downscale_2x2_box #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_i        (pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_pixel_o    (out_pixel_o),
    .last_in_row_o  (last_in_row_o),
    .last_in_frame_o(last_in_frame_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the downscaler: registers, counters, held pixel and line of pair
  // sums, all at the block's widths. Advanced once per accepted pixel.
  // ---------------------------------------------------------------------------
  logic [WIDTH_W-1:0]  width_reg  = WIDTH_RST;
  logic [HEIGHT_W-1:0] height_reg = HEIGHT_RST;
  logic [10:0]         col_cnt    = '0;
  logic [11:0]         row_cnt    = '0;
  pixel_t              held_px    = '0;
  psum_t               pair_line [LINE_SLOTS];

  pixel_t      pixel_q[$];   // pixels still to be offered
  shrunk_px_t  shrunk_q[$];  // averaged pixels still owed by the block

  int unsigned cycle_count = 0;
  int          err_count   = 0;
  logic        in_taken    = 1'b0;  // input transaction at the last rising edge
  int          burst_left  = 0;
  int          gap_left    = 0;
  logic [5:0]  stall_tick  = '0;
  logic [7:0]  stall_pat   = '1;

  // zero reads as one, anything above the maximum saturates
  function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // channels lean towards 0x00 and 0xFF so the floor and the carries get hit
  function automatic pixel_t rand_pixel();
    pixel_t p;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      case ($urandom_range(0, 5))
        0:       p[ch*CH_W +: CH_W] = 8'h00;
        1:       p[ch*CH_W +: CH_W] = 8'hFF;
        default: p[ch*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0:       return 13'd0;
          1:       return 13'd1;
          2:       return 13'd2048;
          3:       return 13'd2049;
          4:       return 13'd4095;
          default: return 13'd4096;  // bit 12 lost in the register: width 0
        endcase
      end
      1:       return CFG_DATA_W'($urandom_range(0, 8191));
      default: return CFG_DATA_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0:       return 13'd0;
          1:       return 13'd1;
          2:       return 13'd2;
          3:       return 13'd4096;
          4:       return 13'd4097;
          default: return 13'd8191;
        endcase
      end
      1:       return CFG_DATA_W'($urandom_range(0, 8191));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  // One pixel into the shadow. Even column: held. Odd column inside the
  // output width: pair sum, stored on an even row, averaged with the stored
  // one on an odd row inside the output height. Counters wrap against the
  // current registers, so a shrink mid-frame wraps at once.
  task automatic absorb_pixel(input pixel_t px);
    int unsigned       w;
    int unsigned       h;
    int unsigned       out_w;
    int unsigned       out_h;
    logic [9:0]        slot;
    psum_t             bottom;
    logic [CH_SUM_W:0] quad;
    shrunk_px_t        res;
    w     = clamp_dim(width_reg, MAX_W);
    h     = clamp_dim(height_reg, MAX_H);
    out_w = w / 2;
    out_h = h / 2;
    slot  = col_cnt[10:1];
    if (!col_cnt[0]) begin
      held_px = px;
    end else if (col_cnt < 2 * out_w) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        bottom[ch*CH_SUM_W +: CH_SUM_W] = {1'b0, held_px[ch*CH_W +: CH_W]} +
                                          {1'b0, px[ch*CH_W +: CH_W]};
      end
      if (!row_cnt[0]) begin
        pair_line[slot] = bottom;
      end else if (row_cnt < 2 * out_h) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          quad = {1'b0, pair_line[slot][ch*CH_SUM_W +: CH_SUM_W]} +
                 {1'b0, bottom[ch*CH_SUM_W +: CH_SUM_W]};
          res.avg[ch*CH_W +: CH_W] = quad[CH_SUM_W:2];
        end
        res.row_end   = (col_cnt[10:1] == out_w - 1);
        res.frame_end = res.row_end && (row_cnt[11:1] == out_h - 1);
        shrunk_q.push_back(res);
      end
    end
    if (col_cnt >= w - 1) begin
      col_cnt = '0;
      row_cnt = (row_cnt >= h - 1) ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
      if (row_cnt >= h) row_cnt = '0;
    end
  endtask

  task automatic flag_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("cycle %0d: %s", cycle_count, what);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled on the rising edge, before the block updates.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    shrunk_px_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_IMAGE_WIDTH) width_reg = cfg_data_i[WIDTH_W-1:0];
        else if (cfg_index_i == REG_IMAGE_HEIGHT) height_reg = cfg_data_i[HEIGHT_W-1:0];
      end
      if (in_valid_i && in_ready_o) absorb_pixel(pixel_i);
      if (out_valid_o && out_ready_i) begin
        if (shrunk_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected output transaction, pixel %06h",
                                  out_pixel_o));
        end else begin
          want = shrunk_q.pop_front();
          if (out_pixel_o !== want.avg || last_in_row_o !== want.row_end ||
              last_in_frame_o !== want.frame_end)
            flag_mismatch($sformatf("got pixel %06h row_end %b frame_end %b, want %06h %b %b",
                                    out_pixel_o, last_in_row_o, last_in_frame_o,
                                    want.avg, want.row_end, want.frame_end));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them. Valid is held
  // with its pixel until the transaction is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_taken) pixel_q.delete(0);
      if (!in_valid_i || in_taken) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pixel_q.size() != 0) begin
          in_valid_i <= 1'b1;
          pixel_i    <= pixel_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            // a third of bursts run straight into the next one
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows an 8-bit pattern, redrawn whenever stall_tick wraps.
  // Often all ones; never all zeros, so no stall lasts long.
  always @(negedge clk_i) begin
    if (stall_tick == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      if (stall_pat == 8'h00) stall_pat = 8'h01;
    end
    stall_tick  <= stall_tick + 1'b1;
    out_ready_i <= stall_pat[stall_tick[2:0]];
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[rgb_downscale_2x2_box] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers. Pixels are queued on the rising edge so the driver
  // never sees the queue change under it.
  // ---------------------------------------------------------------------------
  task automatic send_pixels(input pixel_t list[$]);
    @(posedge clk_i);
    foreach (list[i]) pixel_q.push_back(list[i]);
  endtask

  task automatic send_random(input int unsigned n);
    @(posedge clk_i);
    repeat (n) pixel_q.push_back(rand_pixel());
  endtask

  // Nothing left to offer and nothing owed, then a short pause: a trailing
  // pixel that yields no output may still be inside the block.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || shrunk_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus. The line buffer is undefined after reset, so every slot is read
  // only after an even row has written it: the directed frames are aligned,
  // and the widest frame fills every slot before any random frame.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    pixel_t                seq[$];
    logic [CFG_DATA_W-1:0] w_val;
    logic [CFG_DATA_W-1:0] h_val;
    int unsigned           w;
    int unsigned           h;
    int unsigned           frame;
    int unsigned           n;
    int unsigned           sent;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // 2x2 at the reset sizes, every channel at full scale
    seq = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
    send_pixels(seq);
    wait_drained();

    // write to the unused index, then odd width and height: last column and
    // last row dropped, one output pixel; floors with sums just under 4k
    write_reg(REG_SPARE, '1);
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    seq = '{24'h01FF00, 24'h01FF7F, 24'h123456,
            24'h0100FF, 24'h00FE80, 24'hABCDEF,
            24'h000000, 24'hFFFFFF, 24'h5A5A5A};
    send_pixels(seq);
    wait_drained();

    // 4x2, stopped part-way through the odd row, then narrowed to 2: the
    // column is past the new last one and wraps, closing the frame
    write_reg(REG_IMAGE_WIDTH, 13'd4);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    seq = '{24'h000000, 24'h000000, 24'h030303, 24'h808080,
            24'h000000, 24'h010101};
    send_pixels(seq);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 13'd2);
    seq = '{24'hC0FFEE, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h7F7F7F};
    send_pixels(seq);
    wait_drained();

    // zero width and height behave as 1x1: never an output
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    seq = '{24'hFFFFFF, 24'h000000};
    send_pixels(seq);
    wait_drained();

    // widest frame, width saturating from 4095: the even row fills the whole
    // line buffer, a short stretch of the odd row shows the wrap at 2048
    write_reg(REG_IMAGE_WIDTH, 13'd4095);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    send_random(MAX_W + 16);
    wait_drained();

    // Random sizes. Most phases first finish a small frame in progress and
    // then send whole frames; the rest change size mid-frame or stop mid-frame.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      if ((col_cnt != 0 || row_cnt != 0) && col_cnt < w && row_cnt < h &&
          w * h <= 96 && $urandom_range(0, 3) != 0) begin
        n = (h - row_cnt) * w - col_cnt;
        send_random(n);
        sent += n;
        wait_drained();
      end
      w_val = pick_width();
      h_val = pick_height();
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, w_val);
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, h_val);
      if ($urandom_range(0, 15) == 0)
        write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 8191)));
      w     = clamp_dim(width_reg, MAX_W);
      h     = clamp_dim(height_reg, MAX_H);
      frame = w * h;
      if (frame <= 96) begin
        n = frame * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, frame);
      end else begin
        // huge frames: only a slice, left unfinished
        n = $urandom_range(1, 96);
      end
      send_random(n);
      sent += n;
      wait_drained();
    end

    // anything arriving now is unexpected and gets flagged by the monitor
    repeat (8) @(negedge clk_i);
    if (err_count == 0) begin
      $display("[rgb_downscale_2x2_box] OK");
    end else begin
      $display("[rgb_downscale_2x2_box] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rgbds_pkg.sv
hdl/rgbds_ram.sv
hdl/rgb_downscale_2x2_box.sv
tb/rgb_downscale_2x2_box_tb.sv
